// ===== rtl/clfmt_pkg.sv =====
package clfmt_pkg;

    localparam int BIN_W          = 32;
    localparam int NUM_BCD        = 10;
    localparam int DEF_MAX_DIGITS = 10;
    localparam int GLYPH_ROWS     = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] SET_DDRAM    = 8'h80;
    localparam logic [7:0] SET_CGRAM    = 8'h40;
    localparam logic [6:0] ROW1_OFFSET  = 7'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] CLEAR_RESET  = 8'h01;

    typedef enum logic [2:0] {
        OP_DATA   = 3'd0,
        OP_GOTO   = 3'd1,
        OP_NUMBER = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_GLYPH  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        K_SINGLE = 2'd0,
        K_NUMBER = 2'd1,
        K_GLYPH  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_CONV,
        ST_DIGIT,
        ST_GLYPH
    } t_state;

    // One classified request as it waits between front and back.
    typedef struct packed {
        t_kind             kind;
        logic              rs;
        logic [7:0]        bus_byte;
        logic              pos_valid;
        logic [BIN_W-1:0]  number;
        logic              over;
        logic [2:0]        slot;
        logic [63:0]       pattern;
    } t_cmd;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] v;
        v = 64'd1;
        for (int i = 0; i < n; i++) begin
            v = v * 64'd10;
        end
        return v;
    endfunction

endpackage

// ===== rtl/clfmt_front.sv =====
module clfmt_front import clfmt_pkg::*; #(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_accept,
    input  logic [2:0]       i_opcode,
    input  logic [7:0]       i_data_byte,
    input  logic [1:0]       i_row,
    input  logic [5:0]       i_column,
    input  logic [BIN_W-1:0] i_number,
    input  logic [2:0]       i_glyph_slot,
    input  logic [63:0]      i_pattern_rows,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam int D_EFF = (MAX_DIGITS < NUM_BCD) ? MAX_DIGITS : NUM_BCD;
    localparam logic [63:0] LIMIT = pow10(D_EFF);

    logic [7:0] r_clear_cmd;
    logic [7:0] pos_byte;
    logic       pos_valid;
    logic       over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_cmd <= CLEAR_RESET;
        end else if (i_cfg_we) begin
            r_clear_cmd <= i_cfg_wdata;
        end
    end

    always_comb begin
        pos_valid = (i_row == 2'd0) || (i_row == 2'd1);
        if (i_row == 2'd1) begin
            pos_byte = SET_DDRAM | {1'b0, ROW1_OFFSET + {1'b0, i_column}};
        end else begin
            pos_byte = SET_DDRAM | {2'b00, i_column};
        end
        // Value has more digits than we print: keep all low digits, zeros too.
        if (D_EFF >= NUM_BCD) begin
            over = 1'b0;
        end else begin
            over = ({32'd0, i_number} >= LIMIT);
        end
    end

    always_comb begin
        o_cmd.kind      = K_SINGLE;
        o_cmd.rs        = 1'b0;
        o_cmd.bus_byte  = pos_byte;
        o_cmd.pos_valid = pos_valid;
        o_cmd.number    = i_number;
        o_cmd.over      = over;
        o_cmd.slot      = i_glyph_slot;
        o_cmd.pattern   = i_pattern_rows;
        o_push          = 1'b0;
        case (i_opcode)
            OP_DATA: begin
                o_cmd.rs       = 1'b1;
                o_cmd.bus_byte = i_data_byte;
                o_push         = i_accept;
            end
            OP_GOTO: begin
                o_push = i_accept && pos_valid;
            end
            OP_NUMBER: begin
                o_cmd.kind = K_NUMBER;
                o_push     = i_accept;
            end
            OP_CLEAR: begin
                o_cmd.bus_byte = r_clear_cmd;
                o_push         = i_accept;
            end
            OP_GLYPH: begin
                o_cmd.kind = K_GLYPH;
                o_push     = i_accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/clfmt_queue.sv =====
module clfmt_queue import clfmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_wdata,
    input  logic i_pop,
    output t_cmd o_rdata,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/clfmt_back.sv =====
module clfmt_back import clfmt_pkg::*; #(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_q_empty,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic       o_register_select,
    output logic [7:0] o_bus_byte,
    output logic       o_last_write
);

    localparam int D_EFF = (MAX_DIGITS < NUM_BCD) ? MAX_DIGITS : NUM_BCD;
    localparam int IDX_W = $clog2(NUM_BCD);
    localparam int CNT_W = $clog2(BIN_W);
    localparam int BCD_W = 4 * NUM_BCD;
    localparam logic [3:0] STEP_POS  = 4'(GLYPH_ROWS + 1);
    localparam logic [3:0] STEP_SLOT = 4'(GLYPH_ROWS + 2);

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [BIN_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_started, n_started;
    logic [3:0]       r_step, n_step;
    logic             r_out_valid, n_out_valid;
    logic             r_rs, n_rs;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;

    logic             can_emit;
    logic [BCD_W-1:0] bcd_adj;
    logic [3:0]       digit;
    logic [2:0]       row_sel;

    assign o_empty           = !r_out_valid;
    assign o_register_select = r_rs;
    assign o_bus_byte        = r_byte;
    assign o_last_write      = r_last;
    assign can_emit          = !r_out_valid || i_pop;
    assign digit             = r_bcd[4*r_idx +: 4];
    assign row_sel           = 3'(r_step - 4'd1);

    always_comb begin
        for (int d = 0; d < NUM_BCD; d++) begin
            bcd_adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                          : r_bcd[4*d +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_cnt     <= n_cnt;
        r_idx     <= n_idx;
        r_started <= n_started;
        r_step    <= n_step;
        r_rs      <= n_rs;
        r_byte    <= n_byte;
        r_last    <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_started   = r_started;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_pop;
        n_rs        = r_rs;
        n_byte      = r_byte;
        n_last      = r_last;
        o_q_pop     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_cmd;
                    n_bin   = i_cmd.number;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_step  = '0;
                    case (i_cmd.kind)
                        K_SINGLE: n_state = ST_SINGLE;
                        K_NUMBER: n_state = ST_CONV;
                        K_GLYPH:  n_state = ST_GLYPH;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SINGLE: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_rs        = r_cmd.rs;
                    n_byte      = r_cmd.bus_byte;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_CONV: begin
                {n_bcd, n_bin} = {bcd_adj, r_bin} << 1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(BIN_W - 1)) begin
                    n_idx     = IDX_W'(D_EFF - 1);
                    n_started = r_cmd.over;
                    n_state   = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (!r_started && digit == 4'd0 && r_idx != '0) begin
                    n_idx = r_idx - 1'b1;
                end else if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_rs        = 1'b1;
                    n_byte      = ASCII_ZERO + {4'd0, digit};
                    n_last      = (r_idx == '0);
                    n_started   = 1'b1;
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            ST_GLYPH: begin
                if (r_step == STEP_POS && !r_cmd.pos_valid) begin
                    n_step = STEP_SLOT;
                end else if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_last      = 1'b0;
                    n_step      = r_step + 4'd1;
                    if (r_step == '0) begin
                        n_rs   = 1'b0;
                        n_byte = SET_CGRAM | {2'b00, r_cmd.slot, 3'b000};
                    end else if (r_step == STEP_POS) begin
                        n_rs   = 1'b0;
                        n_byte = r_cmd.bus_byte;
                    end else if (r_step == STEP_SLOT) begin
                        n_rs    = 1'b1;
                        n_byte  = {5'd0, r_cmd.slot};
                        n_last  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_rs   = 1'b1;
                        n_byte = r_cmd.pattern[8*row_sel +: 8];
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/char_lcd_write_formatter_unit.sv =====
// Path: the front end classifies an accepted request combinationally and pushes it into
//   the queue; the idle back end takes it into its command register, and every write
//   leaves through a registered output. A number first runs the binary-to-BCD loop, then
//   skips leading zeros before its digits are written. The back end works on one request
//   at a time while the queue holds more; low pop stalls the writes.
// Reset (i_rst_n low, synchronous): queue emptied, clear command set to 0x01.
module char_lcd_write_formatter_unit import clfmt_pkg::*; #(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             push,
    output logic             full,
    input  logic [2:0]       i_opcode,
    input  logic [7:0]       i_data_byte,
    input  logic [1:0]       i_row,
    input  logic [5:0]       i_column,
    input  logic [BIN_W-1:0] i_number,
    input  logic [2:0]       i_glyph_slot,
    input  logic [63:0]      i_pattern_rows,
    output logic             empty,
    input  logic             pop,
    output logic             o_register_select,
    output logic [7:0]       o_bus_byte,
    output logic             o_last_write
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_wdata;
    t_cmd q_rdata;

    assign full = q_full;

    clfmt_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (push && !q_full),
        .i_opcode       (i_opcode),
        .i_data_byte    (i_data_byte),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_number       (i_number),
        .i_glyph_slot   (i_glyph_slot),
        .i_pattern_rows (i_pattern_rows),
        .o_push         (q_push),
        .o_cmd          (q_wdata)
    );

    clfmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    clfmt_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (q_rdata),
        .i_q_empty         (q_empty),
        .o_q_pop           (q_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_register_select (o_register_select),
        .o_bus_byte        (o_bus_byte),
        .o_last_write      (o_last_write)
    );

    a_queue_push_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (push && !full))
        else $error("queue written without an accepted request");

    a_queue_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && !q_empty) |=> !q_full)
        else $error("queue still full after a request moved to the back end");

    a_queue_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("back end took a request from an empty queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("results pending after reset");

endmodule
